// ===== hdl/pesd_pkg.sv =====
// Package for the PES reassembly deframer: widths, stream-id codes,
// start-phase codes and the per-PID context record. No dependencies.
`default_nettype none

package pesd_pkg;

  localparam int PID_W          = 13;
  localparam int PID_COUNT      = 8192;
  localparam int CTX_AW         = (PID_COUNT > 2) ? $clog2(PID_COUNT) : 1;
  localparam int OPT_HEADER_MIN = 3;
  localparam int POS_W          = 9;
  localparam int HLEN_W         = 8;
  localparam int PHASE_W        = 3;

  // Start phase: number of start bytes still to consume.
  localparam logic [PHASE_W-1:0] PH_BODY = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEN1 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEN0 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ID   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PFX2 = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PFX1 = 3'd5;
  localparam logic [PHASE_W-1:0] PH_PFX0 = 3'd6;

  localparam logic [7:0] PFX_ZERO = 8'h00;
  localparam logic [7:0] PFX_ONE  = 8'h01;

  // Low bytes of the stream ids (0x1xx) refused when filtering is on.
  localparam logic [7:0] SID_PROGRAM_MAP = 8'hBC;
  localparam logic [7:0] SID_PRIVATE2    = 8'hBF;
  localparam logic [7:0] SID_ECM         = 8'hF0;
  localparam logic [7:0] SID_EMM         = 8'hF1;
  localparam logic [7:0] SID_DSMCC       = 8'hF2;
  localparam logic [7:0] SID_TYPE_E      = 8'hF8;
  localparam logic [7:0] SID_DIRECTORY   = 8'hFF;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_START,
    OP_BODY
  } op_t;

  typedef struct packed {
    logic              active;
    logic [POS_W-1:0]  pos;
    logic [HLEN_W-1:0] hlen;
  } ctx_t;

  function automatic logic id_rejected(input logic [7:0] sid);
    id_rejected = (sid == SID_PROGRAM_MAP) || (sid == SID_PRIVATE2) ||
                  (sid == SID_ECM) || (sid == SID_EMM) || (sid == SID_DSMCC) ||
                  (sid == SID_TYPE_E) || (sid == SID_DIRECTORY);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pes_reassembly_deframer.sv =====
// Top level of the PES reassembly deframer: start-code checking, per-PID
// context memory with read-modify-write and the output register.
// Depends on pesd_pkg.
`default_nettype none

// The block takes one PES-portion word of a transport packet per cycle,
// tagged with its PID, the unit-start flag and a first-word marker, and
// gives at most one result word for it: either a payload byte of an open
// PES packet or an end marker that closes the previous PES on that PID
// when a new, accepted start arrives. A new word is accepted in every cycle
// while the output side keeps up; each word makes one read-modify-write of
// its PID's context, read from a single-port-per-side memory in the
// accepting cycle and written back when the word leaves the second
// stage, at the edge at which its result is loaded into the output
// register. Back-to-back words on the same PID are served by forwarding
// the write-back value. After reset the context memory is cleared one
// entry a cycle over all PID_COUNT (8192) entries; in_ready stays low
// during that pass, while configuration writes are taken as usual. The
// filter register may only be written when no word is in flight.
module pes_reassembly_deframer (
  input  wire                        clk,
  input  wire                        rst_n,
  // Configuration
  input  wire                        cfg_wr_en,
  input  wire                        cfg_wr_data,
  // Input words
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [pesd_pkg::PID_W-1:0] in_pid,
  input  wire                        in_unit_start,
  input  wire                        in_packet_first,
  input  wire  [7:0]                 in_data_byte,
  // Result words
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic                       out_kind,
  output logic [pesd_pkg::PID_W-1:0] out_pid,
  output logic [7:0]                 out_payload_byte,
  output logic                       out_pes_first
);
  import pesd_pkg::*;

  // Configuration and framing state
  logic               filter_en_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               drop_r, drop_nxt;

  // Clearing pass
  logic               clearing_r;
  logic [CTX_AW-1:0]  clr_addr_r;

  // Context memory
  ctx_t               ctx_mem [PID_COUNT];
  ctx_t               rd_data_r;
  logic               ctx_we;
  logic [CTX_AW-1:0]  ctx_waddr;
  ctx_t               ctx_wdata;

  // Second stage
  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [PID_W-1:0]   s1_pid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_hit_r;
  ctx_t               s1_fwd_r;
  logic               s1_adv;

  // Output register
  logic               out_valid_r;
  logic               out_kind_r;
  logic [PID_W-1:0]   out_pid_r;
  logic [7:0]         out_byte_r;
  logic               out_first_r;

  logic               in_acc;
  logic               has_ctx;
  logic [PHASE_W-1:0] eff_phase;
  logic               eff_drop;
  op_t                op_nxt;

  ctx_t               cur_ctx;
  ctx_t               upd_ctx;
  logic               upd_we;
  logic               emit;
  logic               emit_kind;
  logic [7:0]         emit_byte;
  logic               emit_first;
  logic [POS_W-1:0]   start_pos;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;
  assign has_ctx  = ({1'b0, in_pid} < (PID_W + 1)'(PID_COUNT));

  // Start-code and drop tracking. This state is global, not per PID, so it
  // is resolved in the accepting cycle and only the context work is passed on.
  always_comb begin
    eff_phase = in_packet_first ? (in_unit_start ? PH_PFX0 : PH_BODY) : phase_r;
    eff_drop  = in_packet_first ? 1'b0 : drop_r;
    phase_nxt = eff_phase;
    drop_nxt  = eff_drop;
    op_nxt    = OP_NONE;
    if (!eff_drop) begin
      if (eff_phase == PH_BODY) begin
        if (has_ctx) begin
          op_nxt = OP_BODY;
        end
      end else begin
        phase_nxt = eff_phase - PHASE_W'(1);
        case (eff_phase)
          PH_PFX0, PH_PFX1: begin
            if (in_data_byte != PFX_ZERO) begin
              drop_nxt  = 1'b1;
              phase_nxt = PH_BODY;
            end
          end
          PH_PFX2: begin
            if (in_data_byte != PFX_ONE) begin
              drop_nxt  = 1'b1;
              phase_nxt = PH_BODY;
            end
          end
          PH_ID: begin
            if (filter_en_r && id_rejected(in_data_byte)) begin
              drop_nxt  = 1'b1;
              phase_nxt = PH_BODY;
            end else if (has_ctx) begin
              op_nxt = OP_START;
            end
          end
          default: begin
            // Length bytes are skipped.
          end
        endcase
      end
    end
  end

  // Context update for the word in the second stage. The forwarded value
  // stands in when the previous word wrote this entry on the edge at which
  // this word's read was taken.
  always_comb begin
    cur_ctx    = s1_hit_r ? s1_fwd_r : rd_data_r;
    upd_ctx    = cur_ctx;
    upd_we     = 1'b0;
    emit       = 1'b0;
    emit_kind  = KIND_PAYLOAD;
    emit_byte  = 8'h00;
    emit_first = 1'b0;
    start_pos  = POS_W'(cur_ctx.hlen) + POS_W'(OPT_HEADER_MIN);
    case (s1_op_r)
      OP_START: begin
        if (cur_ctx.active) begin
          emit      = 1'b1;
          emit_kind = KIND_END;
        end
        upd_ctx.active = 1'b1;
        upd_ctx.pos    = '0;
        upd_ctx.hlen   = '0;
        upd_we         = 1'b1;
      end
      OP_BODY: begin
        if (cur_ctx.active) begin
          if (cur_ctx.pos < POS_W'(2)) begin
            upd_ctx.pos = cur_ctx.pos + POS_W'(1);
            upd_we      = 1'b1;
          end else if (cur_ctx.pos == POS_W'(2)) begin
            upd_ctx.hlen = s1_byte_r;
            upd_ctx.pos  = POS_W'(3);
            upd_we       = 1'b1;
          end else if (cur_ctx.pos < start_pos) begin
            upd_ctx.pos = cur_ctx.pos + POS_W'(1);
            upd_we      = 1'b1;
          end else begin
            emit      = 1'b1;
            emit_byte = s1_byte_r;
            if (cur_ctx.pos == start_pos) begin
              emit_first  = 1'b1;
              upd_ctx.pos = start_pos + POS_W'(1);
              upd_we      = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Memory write port: clearing pass after reset, else the write-back.
  always_comb begin
    if (clearing_r) begin
      ctx_we    = 1'b1;
      ctx_waddr = clr_addr_r;
      ctx_wdata = '0;
    end else begin
      ctx_we    = s1_adv && upd_we;
      ctx_waddr = s1_pid_r[CTX_AW-1:0];
      ctx_wdata = upd_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctx_we) begin
      ctx_mem[ctx_waddr] <= ctx_wdata;
    end
    if (in_acc) begin
      rd_data_r <= ctx_mem[in_pid[CTX_AW-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b1;
      phase_r     <= PH_BODY;
      drop_r      <= 1'b0;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        filter_en_r <= cfg_wr_data;
      end
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + CTX_AW'(1);
        if (clr_addr_r == CTX_AW'(PID_COUNT - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
        drop_r  <= drop_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_nxt;
      s1_pid_r  <= in_pid;
      s1_byte_r <= in_data_byte;
      s1_hit_r  <= ctx_we && (ctx_waddr == in_pid[CTX_AW-1:0]);
      s1_fwd_r  <= ctx_wdata;
    end
    if (s1_adv) begin
      out_kind_r  <= emit_kind;
      out_pid_r   <= s1_pid_r;
      out_byte_r  <= emit_byte;
      out_first_r <= emit_first;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_pid          = out_pid_r;
  assign out_payload_byte = out_byte_r;
  assign out_pes_first    = out_first_r;

  // A dropped packet always leaves the start phase at body.
  a_drop_phase : assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (phase_r == PH_BODY))
    else $error("packet drop set with a start phase pending");

  // No word enters or is held in the pipeline during the clearing pass.
  a_clear_idle : assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!in_ready && !s1_valid_r && !out_valid_r))
    else $error("word in flight during context clearing");

  // Payload leaves only from an open context.
  a_payload_active : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && emit && (emit_kind == KIND_PAYLOAD)) |-> cur_ctx.active)
    else $error("payload emitted from an inactive context");

  // An end marker carries no byte and no first flag.
  a_end_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_END)) |->
      ((out_payload_byte == 8'h00) && !out_pes_first))
    else $error("end marker with payload fields set");

endmodule

`default_nettype wire

// ===== tb/sv/pes_reassembly_deframer_tb.sv =====
// Self-checking testbench for pes_reassembly_deframer: directed start-code cases, then
// random transport packets under both filter settings, with random idling on both sides.
// Depends on pesd_pkg and the pes_reassembly_deframer RTL.
`timescale 1ns / 1ps

module pes_reassembly_deframer_tb;
  import pesd_pkg::*;

  // The clearing pass after reset and the slowest run of about 1800 words,
  // each with a long send gap and a long stall on the result side, stay
  // well under this.
  localparam int unsigned CYCLE_LIMIT  = 600000;
  // This leaves a margin for words still in the block that give no result.
  localparam int          DRAIN_CYCLES = 10;

  localparam logic [PID_W-1:0] PID_LOW  = '0;
  localparam logic [PID_W-1:0] PID_HIGH = '1;

  // Ordinary media stream ids and the usual first flag byte of a PES header.
  localparam logic [7:0] SID_VIDEO   = 8'hE0;
  localparam logic [7:0] SID_AUDIO   = 8'hC0;
  localparam logic [7:0] PES_FLAGS_0 = 8'h80;
  localparam logic [7:0] PES_FLAGS_1 = 8'h80;

  typedef struct packed {
    logic             kind;
    logic [PID_W-1:0] pid;
    logic [7:0]       data;
    logic             pes_first;
  } pes_result_t;

  logic             clk;
  logic             rst_n            = 1'b0;
  logic             cfg_wr_en        = 1'b0;
  logic             cfg_wr_data      = 1'b0;
  logic             in_valid         = 1'b0;
  logic             in_ready;
  logic [PID_W-1:0] in_pid           = '0;
  logic             in_unit_start    = 1'b0;
  logic             in_packet_first  = 1'b0;
  logic [7:0]       in_data_byte     = '0;
  logic             out_valid;
  logic             out_ready        = 1'b0;
  logic             out_kind;
  logic [PID_W-1:0] out_pid;
  logic [7:0]       out_payload_byte;
  logic             out_pes_first;

  pes_reassembly_deframer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pid           (in_pid),
    .in_unit_start    (in_unit_start),
    .in_packet_first  (in_packet_first),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_pid          (out_pid),
    .out_payload_byte (out_payload_byte),
    .out_pes_first    (out_pes_first)
  );

  // Deframer state as the testbench sees it: one context per PID, the count
  // of start bytes still to come, the drop flag and the filter register.
  logic               pes_open   [PID_COUNT];
  logic [POS_W-1:0]   hdr_pos    [PID_COUNT];
  logic [HLEN_W-1:0]  hdr_len    [PID_COUNT];
  logic [PHASE_W-1:0] start_left = PH_BODY;
  logic               dropping   = 1'b0;
  logic               filter_on  = 1'b1;

  pes_result_t  results_due [$];
  int unsigned  error_count = 0;
  int unsigned  words_sent  = 0;
  int unsigned  cycle_count = 0;
  bit           tx_idling   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    for (int p = 0; p < PID_COUNT; p++) begin
      pes_open[p] = 1'b0;
      hdr_pos[p]  = '0;
      hdr_len[p]  = '0;
    end
  end

  // Stream ids that the block refuses while filtering is switched on.
  function automatic bit sid_refused(input logic [7:0] sid);
    case (sid)
      SID_PROGRAM_MAP, SID_PRIVATE2, SID_ECM, SID_EMM,
      SID_DSMCC, SID_TYPE_E, SID_DIRECTORY: return 1'b1;
      default:                              return 1'b0;
    endcase
  endfunction

  // Advances the deframer state by one accepted word and queues the result
  // word that it gives, if any.
  task automatic deframe_word(input logic [PID_W-1:0] pid, input logic unit_start,
                              input logic first, input logic [7:0] data);
    logic [PHASE_W-1:0] phase;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   payload_at;
    pes_result_t        res;
    // A packet boundary clears any drop and decides whether a PES start follows.
    if (first) begin
      dropping   = 1'b0;
      start_left = unit_start ? PH_PFX0 : PH_BODY;
    end
    if (dropping) return;

    if (start_left != PH_BODY) begin
      phase      = start_left;
      start_left = start_left - PHASE_W'(1);
      case (phase)
        PH_PFX0, PH_PFX1: begin
          if (data != PFX_ZERO) begin
            dropping   = 1'b1;
            start_left = PH_BODY;
          end
        end
        PH_PFX2: begin
          if (data != PFX_ONE) begin
            dropping   = 1'b1;
            start_left = PH_BODY;
          end
        end
        PH_ID: begin
          // A refused id drops the packet and leaves the old context alone.
          if (filter_on && sid_refused(data)) begin
            dropping   = 1'b1;
            start_left = PH_BODY;
          end else if (int'(pid) < PID_COUNT) begin
            if (pes_open[pid]) begin
              res = '{kind: KIND_END, pid: pid, data: 8'h00, pes_first: 1'b0};
              results_due.push_back(res);
            end
            pes_open[pid] = 1'b1;
            hdr_pos[pid]  = '0;
            hdr_len[pid]  = '0;
          end
        end
        default: ; // the two length bytes carry nothing that is used
      endcase
      return;
    end

    if (int'(pid) >= PID_COUNT || !pes_open[pid]) return;

    pos        = hdr_pos[pid];
    payload_at = POS_W'(hdr_len[pid]) + POS_W'(OPT_HEADER_MIN);
    if (pos < POS_W'(2)) begin
      hdr_pos[pid] = pos + POS_W'(1);
    end else if (pos == POS_W'(2)) begin
      hdr_len[pid] = data;
      hdr_pos[pid] = POS_W'(3);
    end else if (pos < payload_at) begin
      hdr_pos[pid] = pos + POS_W'(1);
    end else begin
      res = '{kind: KIND_PAYLOAD, pid: pid, data: data, pes_first: (pos == payload_at)};
      results_due.push_back(res);
      // The position stops one past the payload start, so only the first
      // payload byte is marked.
      if (pos == payload_at) hdr_pos[pid] = payload_at + POS_W'(1);
    end
  endtask

  // Send-side gaps: mostly none or short, now and then a long one, and
  // stretches of words with no gaps at all.
  function automatic int pick_gap();
    int r;
    if (!tx_idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one word and holds it until the block takes it, then updates
  // the prediction.
  task automatic send_word(input logic [PID_W-1:0] pid, input logic unit_start,
                           input logic first, input logic [7:0] data);
    int gap;
    if (words_sent % 50 == 0) tx_idling = ($urandom_range(0, 3) != 0);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pid          <= pid;
    in_unit_start   <= unit_start;
    in_packet_first <= first;
    in_data_byte    <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_word(pid, unit_start, first, data);
    words_sent++;
  endtask

  // Lowers valid and waits until every expected result has come out, then
  // gives the block time to finish words that make no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_filter(input logic enable);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= enable;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    filter_on    = enable;
  endtask

  // Result side: out_ready is high most of the time with short and
  // occasional long stalls, and some stretches with no stall at all.
  int unsigned stall_left = 0;
  int unsigned rx_cycles  = 0;
  bit          rx_calm    = 1'b0;

  always @(posedge clk) begin : drive_out_ready
    int r;
    rx_cycles++;
    if (rx_cycles % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        out_ready <= 1'b1;
      end else if (r < 96) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        stall_left = $urandom_range(8, 40);
        out_ready <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Every result word taken at an edge is checked against the oldest
  // expectation.
  always @(posedge clk) begin : check_results
    pes_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word, expected none, got kind %0d pid %0d byte %0d",
                 $time, out_kind, out_pid, out_payload_byte);
      end else begin
        want = results_due.pop_front();
        compare_field("kind", 32'(want.kind), 32'(out_kind));
        compare_field("pid", 32'(want.pid), 32'(out_pid));
        compare_field("payload_byte", 32'(want.data), 32'(out_payload_byte));
        compare_field("pes_first", 32'(want.pes_first), 32'(out_pes_first));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Random stream generation
  // ---------------------------------------------------------------------

  // A few PIDs carry most packets so that PES packets continue over several
  // transport packets; the rest are random over the full PID range.
  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(0, 9) == 0) return PID_W'($urandom_range(0, PID_COUNT - 1));
    case ($urandom_range(0, 4))
      0:       return PID_LOW;
      1:       return PID_HIGH;
      2:       return 13'h0AAA;
      3:       return 13'h1555;
      default: return 13'h0100;
    endcase
  endfunction

  function automatic logic [7:0] pick_stream_id();
    if ($urandom_range(0, 99) >= 30) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0:       return SID_PROGRAM_MAP;
      1:       return SID_PRIVATE2;
      2:       return SID_ECM;
      3:       return SID_EMM;
      4:       return SID_DSMCC;
      5:       return SID_TYPE_E;
      default: return SID_DIRECTORY;
    endcase
  endfunction

  // Mostly short optional headers; a few long ones spread over packets.
  function automatic logic [7:0] pick_header_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(0, 6));
    if (r < 95) return 8'($urandom_range(7, 40));
    return 8'($urandom_range(200, 255));
  endfunction

  function automatic int unsigned pick_packet_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(10, 40);
    if (r < 95) return $urandom_range(1, 9);
    return $urandom_range(100, 184);
  endfunction

  // Sends one transport packet's PES portion. A start packet opens with a
  // proper PES start (prefix, id, length, flags, header length), which may
  // be spoilt in its prefix; everything after that is random.
  task automatic send_pes_packet(input logic [PID_W-1:0] pid, input logic unit_start,
                                 input int unsigned len, input bit spoil_prefix);
    logic [7:0] lead [$];
    logic [7:0] data;
    int         at;
    if (unit_start) begin
      lead = '{PFX_ZERO, PFX_ZERO, PFX_ONE, pick_stream_id(),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               PES_FLAGS_0, PES_FLAGS_1, pick_header_len()};
      if (spoil_prefix) begin
        at       = $urandom_range(0, 2);
        lead[at] = lead[at] ^ 8'($urandom_range(1, 255));
      end
    end
    for (int k = 0; k < len; k++) begin
      data = (k < lead.size()) ? lead[k] : 8'($urandom_range(0, 255));
      send_word(pid, unit_start, (k == 0), data);
    end
  endtask

  // Noise: random words with packet boundaries in odd places.
  task automatic send_noise(input int unsigned len);
    logic [PID_W-1:0] pid;
    pid = pick_pid();
    for (int k = 0; k < len; k++)
      send_word(pid, 1'($urandom_range(0, 1)), (k == 0) || ($urandom_range(0, 15) == 0),
                8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Words before any packet boundary are body words on an inactive PID, and
  // a unit-start flag without a first-word marker is not looked at.
  task automatic test_bytes_before_first_packet();
    send_word(PID_LOW, 1'b1, 1'b0, PFX_ZERO);
    send_word(PID_LOW, 1'b0, 1'b0, 8'hFF);
  endtask

  // An accepted start on the highest PID with an empty optional header; the
  // first payload byte is all ones and marked, the next is zero.
  task automatic test_start_and_payload();
    send_word(PID_HIGH, 1'b1, 1'b1, PFX_ZERO);
    send_word(PID_HIGH, 1'b1, 1'b0, PFX_ZERO);
    send_word(PID_HIGH, 1'b1, 1'b0, PFX_ONE);
    send_word(PID_HIGH, 1'b1, 1'b0, SID_VIDEO);
    send_word(PID_HIGH, 1'b1, 1'b0, 8'h00);
    send_word(PID_HIGH, 1'b1, 1'b0, 8'h00);
    send_word(PID_HIGH, 1'b1, 1'b0, PES_FLAGS_0);
    send_word(PID_HIGH, 1'b1, 1'b0, PES_FLAGS_1);
    send_word(PID_HIGH, 1'b1, 1'b0, 8'h00);
    send_word(PID_HIGH, 1'b1, 1'b0, 8'hFF);
    send_word(PID_HIGH, 1'b1, 1'b0, 8'h00);
  endtask

  // A new start on an open PID gives the end marker as soon as its id is
  // accepted; the start is then cut short by a packet on the lowest PID,
  // which is still inactive, so that word is dropped.
  task automatic test_restart_closes_pes();
    send_word(PID_HIGH, 1'b1, 1'b1, PFX_ZERO);
    send_word(PID_HIGH, 1'b1, 1'b0, PFX_ZERO);
    send_word(PID_HIGH, 1'b1, 1'b0, PFX_ONE);
    send_word(PID_HIGH, 1'b1, 1'b0, SID_AUDIO);
    send_word(PID_LOW, 1'b0, 1'b1, 8'h12);
  endtask

  // A refused id drops the rest of its packet and leaves the reopened
  // context on the highest PID untouched, so a following body packet still
  // reaches its payload. A broken prefix drops its packet too.
  task automatic test_refused_starts();
    send_word(PID_HIGH, 1'b1, 1'b1, PFX_ZERO);
    send_word(PID_HIGH, 1'b1, 1'b0, PFX_ZERO);
    send_word(PID_HIGH, 1'b1, 1'b0, PFX_ONE);
    send_word(PID_HIGH, 1'b1, 1'b0, SID_PROGRAM_MAP);
    send_word(PID_HIGH, 1'b1, 1'b0, PFX_ZERO);
    send_word(PID_HIGH, 1'b0, 1'b1, PES_FLAGS_0);
    send_word(PID_HIGH, 1'b0, 1'b0, PES_FLAGS_1);
    send_word(PID_HIGH, 1'b0, 1'b0, 8'h00);
    send_word(PID_HIGH, 1'b0, 1'b0, 8'hAB);
    send_word(PID_LOW, 1'b1, 1'b1, PFX_ZERO);
    send_word(PID_LOW, 1'b1, 1'b0, 8'h02);
  endtask

  // Random packets with the filter set as given. The filter is only written
  // once the block has gone quiet.
  task automatic test_random_stream(input logic enable, input int unsigned n_words);
    int unsigned first_word;
    int          r;
    wait_idle();
    write_filter(enable);
    first_word = words_sent;
    while (words_sent - first_word < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        send_noise($urandom_range(1, 12));
      else
        send_pes_packet(pick_pid(), ($urandom_range(0, 99) < 45), pick_packet_len(),
                        ($urandom_range(0, 99) < 8));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // The filter register is taken during the clearing pass as well.
    write_filter(1'b1);

    test_bytes_before_first_packet();
    test_start_and_payload();
    test_restart_closes_pes();
    test_refused_starts();

    test_random_stream(1'b0, 450);
    test_random_stream(1'b1, 450);
    test_random_stream(1'b0, 400);
    test_random_stream(1'b1, 450);

    wait_idle();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
